@@ sv/sacf_pkg.sv @@
// shared types and codes for the set-associative cache tag directory
package sacf_pkg;

    // item opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_READ,
        ST_UPDATE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic calc_set;
        logic mem_read;
        logic update;
        logic clear;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_status;

endpackage

@@ sv/sacf_ram.sv @@
// generic single-write, single-read ram with registered read data
module sacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sacf_ctrl.sv @@
// controller state machine for the tag directory
module sacf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sacf_pkg::t_dp_status i_status,
    output sacf_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);

    sacf_pkg::t_state r_state;
    sacf_pkg::t_state n_state;
    logic             busy;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sacf_pkg::ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = sacf_pkg::ST_IDLE;
                end
            end
            sacf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = sacf_pkg::ST_SET;
                end
            end
            sacf_pkg::ST_SET:    n_state = sacf_pkg::ST_READ;
            sacf_pkg::ST_READ:   n_state = sacf_pkg::ST_UPDATE;
            sacf_pkg::ST_UPDATE: n_state = sacf_pkg::ST_IDLE;
            default:             n_state = sacf_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        busy           = (r_state != sacf_pkg::ST_IDLE) || !i_rst_n;
        o_cmd          = '0;
        o_cmd.accept   = i_start && !busy;
        case (r_state)
            sacf_pkg::ST_CLEAR:  o_cmd.clear    = 1'b1;
            sacf_pkg::ST_SET:    o_cmd.calc_set = 1'b1;
            sacf_pkg::ST_READ:   o_cmd.mem_read = 1'b1;
            sacf_pkg::ST_UPDATE: o_cmd.update   = 1'b1;
            default:             o_cmd.clear    = 1'b0;
        endcase
    end

    assign o_busy = busy;

    // an accepted item always starts the set calculation
    a_accept_to_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == sacf_pkg::ST_SET)
        else $error("accepted item did not enter set calculation");

    // the update is a single cycle and returns to idle
    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sacf_pkg::ST_UPDATE |=> r_state == sacf_pkg::ST_IDLE)
        else $error("update did not return to idle");

endmodule

@@ sv/sacf_dp.sv @@
// datapath: address split, set reduction, set row memory, lookup and fill logic
module sacf_dp #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 6,
    parameter int INDEX_BITS  = 6,
    parameter int TAG_BITS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sacf_pkg::t_dp_cmd    i_cmd,
    input  logic [1:0]           i_opcode,
    input  logic [31:0]          i_address,
    output sacf_pkg::t_dp_status o_status,
    output logic                 o_done,
    output logic                 o_hit,
    output logic                 o_wb_valid,
    output logic [31:0]          o_wb_addr
);

    localparam int SET_W       = $clog2(SETS);
    localparam int OFF_W       = (OFFSET_BITS > 0) ? OFFSET_BITS : 1;
    localparam int HEAD_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int COUNT_W     = $clog2(WAYS + 1);
    localparam int ENTRY_W     = TAG_BITS + OFF_W + 1;
    localparam int ENTRIES_W   = WAYS * ENTRY_W;
    localparam int ROW_W       = ENTRIES_W + HEAD_W + COUNT_W;
    localparam int RECIP_SHIFT = INDEX_BITS + 13;
    localparam int PROD_W      = INDEX_BITS + RECIP_SHIFT;
    localparam logic [PROD_W-1:0] RECIP    = PROD_W'((64'd1 << RECIP_SHIFT) / SETS);
    localparam logic [31:0]       OFF_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

    // item registers
    logic [1:0]            r_op;
    logic [TAG_BITS-1:0]   r_tag;
    logic [OFF_W-1:0]      r_off;
    logic [INDEX_BITS-1:0] r_index;
    logic [INDEX_BITS-1:0] r_quot;
    logic [SET_W-1:0]      r_set;
    logic [SET_W-1:0]      r_clr_addr;

    // result registers
    logic        r_done;
    logic        r_hit;
    logic        r_wb_valid;
    logic [31:0] r_wb_addr;

    logic [63:0]           addr_ext;
    logic [TAG_BITS-1:0]   in_tag;
    logic [INDEX_BITS-1:0] in_index;
    logic [OFF_W-1:0]      in_off;
    logic [PROD_W-1:0]     quot_prod;
    logic [PROD_W-1:0]     back_prod;
    logic [INDEX_BITS-1:0] rem_raw;
    logic [INDEX_BITS-1:0] rem_fix;

    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    new_row;
    logic [TAG_BITS-1:0] rd_tag   [WAYS];
    logic [OFF_W-1:0]    rd_off   [WAYS];
    logic                rd_dirty [WAYS];
    logic [HEAD_W-1:0]   rd_head;
    logic [COUNT_W-1:0]  rd_count;

    logic              found;
    logic [HEAD_W-1:0] sel;
    logic              full;
    logic [HEAD_W:0]   fill_sum;
    logic [HEAD_W-1:0] fill_slot;
    logic [HEAD_W-1:0] head_next;
    logic [63:0]       wb_full;
    logic              wb_hit;
    logic              mem_we;

    // split the incoming address; bits above bit 31 read as zero
    assign addr_ext  = {32'd0, i_address};
    assign in_tag    = TAG_BITS'(addr_ext >> (OFFSET_BITS + INDEX_BITS));
    assign in_index  = INDEX_BITS'(addr_ext >> OFFSET_BITS);
    assign in_off    = OFF_W'(i_address & OFF_MASK);
    // quotient estimate by reciprocal, at most one short
    assign quot_prod = PROD_W'(in_index) * RECIP;

    // capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_opcode;
            r_tag   <= in_tag;
            r_off   <= in_off;
            r_index <= in_index;
            r_quot  <= INDEX_BITS'(quot_prod >> RECIP_SHIFT);
        end
    end

    // index modulo sets with one correction step
    assign back_prod = PROD_W'(r_quot) * PROD_W'(SETS);
    assign rem_raw   = r_index - INDEX_BITS'(back_prod);
    assign rem_fix   = (32'(rem_raw) >= 32'(SETS)) ? rem_raw - INDEX_BITS'(SETS) : rem_raw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_set) begin
            r_set <= SET_W'(rem_fix);
        end
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clear_last = (r_clr_addr == SET_W'(SETS - 1));

    // one row per set: all ways plus fifo head and fill count
    assign mem_we = i_cmd.clear ||
                    (i_cmd.update && ((r_op == sacf_pkg::OP_FILL) ||
                                      ((r_op == sacf_pkg::OP_WRITE) && found)));

    sacf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_cmd.clear ? r_clr_addr : r_set),
        .i_wdata (i_cmd.clear ? {ROW_W{1'b0}} : new_row),
        .i_re    (i_cmd.mem_read),
        .i_raddr (r_set),
        .o_rdata (rd_row)
    );

    // unpack the row
    for (genvar w = 0; w < WAYS; w++) begin : g_unpack
        assign rd_tag[w]   = rd_row[w*ENTRY_W +: TAG_BITS];
        assign rd_off[w]   = rd_row[w*ENTRY_W + TAG_BITS +: OFF_W];
        assign rd_dirty[w] = rd_row[w*ENTRY_W + ENTRY_W - 1];
    end
    assign rd_head  = rd_row[ENTRIES_W +: HEAD_W];
    assign rd_count = rd_row[ENTRIES_W + HEAD_W +: COUNT_W];

    // oldest matching way, walking the fifo from its head
    always_comb begin : p_search
        logic [HEAD_W:0]   sum;
        logic [HEAD_W-1:0] way;
        found = 1'b0;
        sel   = '0;
        for (int a = 0; a < WAYS; a++) begin
            sum = (HEAD_W+1)'(rd_head) + (HEAD_W+1)'(a);
            if (sum >= (HEAD_W+1)'(WAYS)) begin
                sum = sum - (HEAD_W+1)'(WAYS);
            end
            way = HEAD_W'(sum);
            if (!found && (COUNT_W'(a) < rd_count) && (rd_tag[way] == r_tag)) begin
                found = 1'b1;
                sel   = way;
            end
        end
    end

    // fill slot and head advance
    assign full      = rd_count >= COUNT_W'(WAYS);
    assign fill_sum  = ((HEAD_W+1)'(rd_head) + (HEAD_W+1)'(rd_count) >= (HEAD_W+1)'(WAYS))
                       ? (HEAD_W+1)'(rd_head) + (HEAD_W+1)'(rd_count) - (HEAD_W+1)'(WAYS)
                       : (HEAD_W+1)'(rd_head) + (HEAD_W+1)'(rd_count);
    assign fill_slot = full ? rd_head : HEAD_W'(fill_sum);
    assign head_next = (rd_head == HEAD_W'(WAYS - 1)) ? '0 : rd_head + 1'b1;

    // updated row
    always_comb begin
        new_row = rd_row;
        case (r_op)
            sacf_pkg::OP_WRITE: begin
                if (found) begin
                    new_row[sel*ENTRY_W + ENTRY_W - 1] = 1'b1;
                end
            end
            sacf_pkg::OP_FILL: begin
                new_row[fill_slot*ENTRY_W +: ENTRY_W] = {1'b0, r_off, r_tag};
                new_row[ENTRIES_W +: HEAD_W]          = full ? head_next : rd_head;
                new_row[ENTRIES_W + HEAD_W +: COUNT_W] =
                    full ? COUNT_W'(WAYS) : COUNT_W'(rd_count + 1'b1);
            end
            default: new_row = rd_row;
        endcase
    end

    // victim address rebuilt from tag, reduced set and stored offset
    assign wb_full = (((64'(rd_tag[rd_head]) << INDEX_BITS) + 64'(r_set)) << OFFSET_BITS)
                     + 64'(rd_off[rd_head]);
    assign wb_hit  = (r_op == sacf_pkg::OP_FILL) && full && rd_dirty[rd_head];

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_hit      <= ((r_op == sacf_pkg::OP_READ) || (r_op == sacf_pkg::OP_WRITE)) && found;
            r_wb_valid <= wb_hit;
            r_wb_addr  <= wb_hit ? wb_full[31:0] : 32'd0;
        end
    end

    assign o_done     = r_done;
    assign o_hit      = r_hit;
    assign o_wb_valid = r_wb_valid;
    assign o_wb_addr  = r_wb_addr;

    // set number after reduction lies below the set count
    a_set_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> 32'(r_set) < 32'(SETS))
        else $error("reduced set number out of range");

    // a stored fill count never exceeds the number of ways
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> 32'(rd_count) <= 32'(WAYS))
        else $error("fill count beyond way count");

    // a write-back only ever comes from a fill, never with a hit
    a_wb_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_wb_valid) |-> (r_op == sacf_pkg::OP_FILL) && !r_hit)
        else $error("write-back reported for a non-fill item");

endmodule

@@ sv/set_assoc_cache_fifo_writeback_unit.sv @@
// top level of the set-associative write-back cache tag directory with fifo replacement
//
// Input channel: an item (i_opcode, i_address) is taken at a rising edge where start
// is high and busy is low. Opcodes: read lookup, write lookup (marks the oldest
// matching way dirty) and fill (appends to the set fifo, evicting the head if full).
// Result channel: o_done is high for exactly one cycle with o_hit, o_writeback_valid
// and o_writeback_address; the receiver cannot hold results off, so there is no stall.
// Each item passes through set reduction, the registered read of the set row memory
// and the read-modify-write of that row before its result is registered; a new item
// is not taken while one is in progress.
// busy is high from acceptance until the result cycle, and the next item may be
// taken in the same cycle that o_done is high.
// Reset (synchronous, active low) starts a clearing pass that zeroes the fifo head
// and fill count of every set, one set per cycle; busy stays high for its whole
// length. Way contents are only read inside a set's fill count, so they need no
// clearing.
module set_assoc_cache_fifo_writeback_unit #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 6,
    parameter int INDEX_BITS  = 6,
    parameter int TAG_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_address,
    output logic        o_done,
    output logic        o_hit,
    output logic        o_writeback_valid,
    output logic [31:0] o_writeback_address
);

    sacf_pkg::t_dp_cmd    cmd;
    sacf_pkg::t_dp_status status;

    // controller
    sacf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // datapath
    sacf_dp #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .OFFSET_BITS (OFFSET_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_opcode   (i_opcode),
        .i_address  (i_address),
        .o_status   (status),
        .o_done     (o_done),
        .o_hit      (o_hit),
        .o_wb_valid (o_writeback_valid),
        .o_wb_addr  (o_writeback_address)
    );

endmodule

@@ tb/sv/set_assoc_cache_fifo_writeback_checker.sv @@
// checker for the cache tag directory: predicts each result and compares it with the unit
module set_assoc_cache_fifo_writeback_checker #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int OFFSET_BITS = 6,
    parameter int INDEX_BITS  = 6,
    parameter int TAG_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_address,
    input  logic        o_done,
    input  logic        o_hit,
    input  logic        o_writeback_valid,
    input  logic [31:0] o_writeback_address,
    output int          o_mismatch_count,
    output int          o_pending_count,
    output int          o_hit_count,
    output int          o_writeback_count
);

    localparam int SLOTS = SETS * WAYS;

    typedef struct packed {
        logic        hit;
        logic        wb_valid;
        logic [31:0] wb_addr;
    } t_dir_result;

    // shadow copy of the directory
    logic [31:0] dir_tag    [SLOTS];
    logic [31:0] dir_offset [SLOTS];
    logic        dir_valid  [SLOTS];
    logic        dir_dirty  [SLOTS];
    int unsigned set_head   [SETS];
    int unsigned set_count  [SETS];

    // results still owed by the unit, oldest first
    t_dir_result owed_results[$];
    int          mismatches;
    int          hits_seen;
    int          writebacks_seen;

    // lookup or fill against the shadow directory, updating it as the unit would
    function automatic t_dir_result predict_directory(logic [1:0] op, logic [31:0] addr);
        t_dir_result res;
        logic [63:0] a64;
        logic [63:0] wb;
        int unsigned offs;
        int unsigned set_no;
        int unsigned tag;
        int unsigned head;
        int unsigned cnt;
        int unsigned slot;
        int unsigned victim;
        a64    = {32'd0, addr};
        offs   = int'(a64 & ((64'd1 << OFFSET_BITS) - 1));
        set_no = int'(((a64 >> OFFSET_BITS) & ((64'd1 << INDEX_BITS) - 1)) % SETS);
        tag    = int'((a64 >> (OFFSET_BITS + INDEX_BITS)) & ((64'd1 << TAG_BITS) - 1));
        head   = set_head[set_no] % WAYS;
        cnt    = (set_count[set_no] > WAYS) ? WAYS : set_count[set_no];
        res    = '0;
        case (op)
            sacf_pkg::OP_READ, sacf_pkg::OP_WRITE: begin
                // walk the set from oldest to newest, stop at the first usable match
                for (int i = 0; i < cnt && !res.hit; i++) begin
                    slot = set_no * WAYS + (head + i) % WAYS;
                    if (dir_tag[slot] == tag) begin
                        if (op == sacf_pkg::OP_READ) begin
                            if (dir_valid[slot]) res.hit = 1'b1;
                        end else begin
                            dir_valid[slot] = 1'b1;
                            dir_dirty[slot] = 1'b1;
                            res.hit = 1'b1;
                        end
                    end
                end
            end
            sacf_pkg::OP_FILL: begin
                // full set: drop the head entry, write it back if dirty
                if (cnt >= WAYS) begin
                    victim = set_no * WAYS + head;
                    if (dir_dirty[victim]) begin
                        wb = (((64'(dir_tag[victim]) << INDEX_BITS) + 64'(set_no))
                              << OFFSET_BITS) + 64'(dir_offset[victim]);
                        res.wb_valid = 1'b1;
                        res.wb_addr  = wb[31:0];
                    end
                    head = (head + 1) % WAYS;
                    cnt  = WAYS - 1;
                end
                slot = set_no * WAYS + (head + cnt) % WAYS;
                dir_tag[slot]     = tag;
                dir_offset[slot]  = offs;
                dir_valid[slot]   = 1'b1;
                dir_dirty[slot]   = 1'b0;
                set_head[set_no]  = head;
                set_count[set_no] = cnt + 1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // watch both channels at each edge
    always @(posedge i_clk) begin
        t_dir_result owed;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                dir_tag[s]    = '0;
                dir_offset[s] = '0;
                dir_valid[s]  = 1'b0;
                dir_dirty[s]  = 1'b0;
            end
            for (int s = 0; s < SETS; s++) begin
                set_head[s]  = 0;
                set_count[s] = 0;
            end
            owed_results.delete();
        end else begin
            // result first: it belongs to an item taken earlier
            if ($isunknown(o_done)) begin
                $display("%0t: result strobe unknown, expected 0 or 1, actual %b", $time, o_done);
                mismatches++;
            end else if (o_done) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result with no item waiting, expected none, actual %0b %0b %08h",
                             $time, o_hit, o_writeback_valid, o_writeback_address);
                    mismatches++;
                end else begin
                    owed = owed_results.pop_front();
                    if (o_hit !== owed.hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %b",
                                 $time, owed.hit, o_hit);
                        mismatches++;
                    end
                    if (o_writeback_valid !== owed.wb_valid) begin
                        $display("%0t: writeback_valid mismatch, expected %0b, actual %b",
                                 $time, owed.wb_valid, o_writeback_valid);
                        mismatches++;
                    end
                    if (o_writeback_address !== owed.wb_addr) begin
                        $display("%0t: writeback_address mismatch, expected %08h, actual %08h",
                                 $time, owed.wb_addr, o_writeback_address);
                        mismatches++;
                    end
                    if (owed.hit) hits_seen++;
                    if (owed.wb_valid) writebacks_seen++;
                end
            end
            // item taken at this edge
            if (start && !busy) owed_results.push_back(predict_directory(i_opcode, i_address));
        end
        o_mismatch_count  <= mismatches;
        o_pending_count   <= owed_results.size();
        o_hit_count       <= hits_seen;
        o_writeback_count <= writebacks_seen;
    end

endmodule

@@ tb/sv/tb_set_assoc_cache_fifo_writeback_unit.sv @@
// testbench top for the cache tag directory: stimulus, watchdog and verdict
module tb_set_assoc_cache_fifo_writeback_unit;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 900;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [31:0] i_address;
    logic        o_done;
    logic        o_hit;
    logic        o_writeback_valid;
    logic [31:0] o_writeback_address;

    int mismatch_count;
    int pending_count;
    int hit_count;
    int writeback_count;
    int items_sent;
    int fills_sent;
    int lookups_sent;
    int unused_sent;
    int idle_cycles;
    int lookup_fill_items;
    bit no_gap;

    logic [15:0] tag_seed;
    logic [5:0]  hot_sets [4];

    set_assoc_cache_fifo_writeback_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_opcode            (i_opcode),
        .i_address           (i_address),
        .o_done              (o_done),
        .o_hit               (o_hit),
        .o_writeback_valid   (o_writeback_valid),
        .o_writeback_address (o_writeback_address)
    );

    set_assoc_cache_fifo_writeback_checker i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_opcode            (i_opcode),
        .i_address           (i_address),
        .o_done              (o_done),
        .o_hit               (o_hit),
        .o_writeback_valid   (o_writeback_valid),
        .o_writeback_address (o_writeback_address),
        .o_mismatch_count    (mismatch_count),
        .o_pending_count     (pending_count),
        .o_hit_count         (hit_count),
        .o_writeback_count   (writeback_count)
    );

    // clock, period 2
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // watchdog on cycles with no item and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one item after a random gap, return at the edge that takes it
    task automatic send_item(logic [1:0] op, logic [31:0] addr);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start     <= 1'b0;
            i_opcode  <= 2'($urandom_range(0, 3));
            i_address <= $urandom;
            for (int k = 1; k < gap; k++) begin
                @(posedge i_clk);
                i_opcode  <= 2'($urandom_range(0, 3));
                i_address <= $urandom;
            end
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_opcode  <= op;
        i_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        case (op)
            sacf_pkg::OP_FILL: fills_sent++;
            OP_UNUSED:         unused_sent++;
            default:           lookups_sent++;
        endcase
    endtask

    // random item, mostly on a few hot sets and tags so that hits and evictions occur
    task automatic send_random_item();
        logic [1:0]  op;
        logic [31:0] addr;
        logic [5:0]  set_no;
        logic [15:0] tag;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            op   = 2'($urandom_range(0, 3));
            addr = $urandom;
        end else begin
            pick = $urandom_range(0, 99);
            op   = (pick < 38) ? sacf_pkg::OP_FILL : (pick < 68) ? sacf_pkg::OP_READ :
                   (pick < 96) ? sacf_pkg::OP_WRITE : OP_UNUSED;
            set_no = ($urandom_range(0, 4) == 0) ? 6'($urandom) : hot_sets[$urandom_range(0, 3)];
            tag    = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                                 : tag_seed ^ 16'($urandom_range(0, 7));
            addr   = {4'($urandom), tag, set_no, 6'($urandom)};
        end
        send_item(op, addr);
        if (op != OP_UNUSED) lookup_fill_items++;
    endtask

    initial begin
        start     <= 1'b0;
        i_opcode  <= sacf_pkg::OP_READ;
        i_address <= '0;
        i_rst_n   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tag_seed    = 16'($urandom);
        hot_sets[0] = 6'd0;
        hot_sets[1] = 6'd63;
        hot_sets[2] = 6'($urandom);
        hot_sets[3] = 6'($urandom);

        // directed: empty set, write miss, fill and hit on set 0
        send_item(sacf_pkg::OP_READ,  32'h0000_0000);
        send_item(sacf_pkg::OP_WRITE, 32'h0000_0000);
        send_item(sacf_pkg::OP_FILL,  32'h0000_002A);
        send_item(sacf_pkg::OP_READ,  32'h0000_0000);
        send_item(sacf_pkg::OP_WRITE, 32'h0000_003F);
        // fill set 0 up, then a duplicate tag that evicts the dirty head
        send_item(sacf_pkg::OP_FILL,  32'h0000_1000);
        send_item(sacf_pkg::OP_FILL,  32'h0000_2000);
        send_item(sacf_pkg::OP_FILL,  32'h0000_3000);
        send_item(sacf_pkg::OP_FILL,  32'h0000_1015);
        send_item(sacf_pkg::OP_WRITE, 32'h0000_1000);
        send_item(sacf_pkg::OP_FILL,  32'h0FFF_F000);
        send_item(sacf_pkg::OP_FILL,  32'h0000_4000);
        // top set and top tag, with the address bits above the tag set
        send_item(sacf_pkg::OP_READ,  32'hFFFF_FFFF);
        send_item(sacf_pkg::OP_FILL,  32'hFFFF_FFFF);
        send_item(sacf_pkg::OP_READ,  32'h0FFF_FFFF);
        send_item(sacf_pkg::OP_WRITE, 32'hF0FF_FFC0);
        send_item(sacf_pkg::OP_FILL,  32'h0000_0FC0);
        send_item(sacf_pkg::OP_FILL,  32'h0000_1FC0);
        send_item(sacf_pkg::OP_FILL,  32'h0000_2FC0);
        send_item(sacf_pkg::OP_FILL,  32'h0000_5FC0);
        // unused opcode
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 32'h0000_0000);
        send_item(sacf_pkg::OP_READ,  32'h0000_1000);

        // random part, with stretches of back-to-back items
        while (lookup_fill_items < RANDOM_ITEMS) begin
            no_gap = ((lookup_fill_items / 40) % 3 == 2);
            send_random_item();
        end
        start <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("summary: %0d items (%0d fills, %0d lookups, %0d unused opcode)",
                 items_sent, fills_sent, lookups_sent, unused_sent);
        $display("summary: %0d lookup hits, %0d dirty evictions written back, %0d mismatches",
                 hit_count, writeback_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/sacf_pkg.sv
sv/sacf_ram.sv
sv/sacf_ctrl.sv
sv/sacf_dp.sv
sv/set_assoc_cache_fifo_writeback_unit.sv
tb/sv/set_assoc_cache_fifo_writeback_checker.sv
tb/sv/tb_set_assoc_cache_fifo_writeback_unit.sv
